// ===== sv/joystick_velocity_shaper_core_macros.svh =====
// assertion macros shared by the velocity shaper modules
// expects aclk and aresetn in the scope of every use
`ifndef JOYSTICK_VELOCITY_SHAPER_CORE_MACROS_SVH
`define JOYSTICK_VELOCITY_SHAPER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define JVS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define JVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jvs_pkg.sv =====
// shared types and constants for the joystick velocity shaper
// no dependencies
package jvs_pkg;

    localparam int AXIS_W  = 16;
    localparam int VEL_W   = 16;
    localparam int LIMIT_W = 15;
    localparam int DZ_W    = 15;
    localparam int STEP_W  = 12;
    localparam int BETA_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_CONT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_STEP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LIN      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_YAW      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIN       = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_YAW       = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BETA           = 8'd7;

    // reset values
    localparam logic               MODE_RST           = 1'b0;
    localparam logic [DZ_W-1:0]    DEAD_ZONE_CONT_RST = 15'd328;
    localparam logic [DZ_W-1:0]    DEAD_ZONE_STEP_RST = 15'd32440;
    localparam logic [LIMIT_W-1:0] LIMIT_LIN_RST      = 15'd2048;
    localparam logic [LIMIT_W-1:0] LIMIT_YAW_RST      = 15'd2048;
    localparam logic [STEP_W-1:0]  STEP_LIN_RST       = 12'd41;
    localparam logic [STEP_W-1:0]  STEP_YAW_RST       = 12'd410;
    localparam logic [BETA_W-1:0]  BETA_RST           = 16'd122;

    // mode codes
    localparam logic MODE_CONT = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // request kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // per-axis control from the top level
    typedef struct packed {
        logic               sample_en;
        logic               tick_en;
        logic               mode;
        logic [DZ_W-1:0]    dz_cont;
        logic [DZ_W-1:0]    dz_step;
        logic [LIMIT_W-1:0] limit;
        logic [STEP_W-1:0]  step;
        logic [BETA_W-1:0]  beta;
    } axis_ctrl_t;

endpackage

// ===== sv/jvs_axis.sv =====
// one velocity channel: target update from an axis sample and low-pass filter
// depends on jvs_pkg and joystick_velocity_shaper_core_macros.svh
`include "joystick_velocity_shaper_core_macros.svh"

module jvs_axis (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  jvs_pkg::axis_ctrl_t                 ctrl,
    input  logic signed [jvs_pkg::AXIS_W-1:0]   axis,
    output logic signed [jvs_pkg::VEL_W-1:0]    vel_next
);
    import jvs_pkg::*;

    logic signed [VEL_W-1:0] target_reg, target_next;
    logic signed [VEL_W-1:0] filt_reg;

    // dead zone tests
    logic signed [AXIS_W:0] axis_ext;
    logic signed [AXIS_W:0] dzc, dzs;
    logic                   cont_hit, step_pos, step_neg;

    assign axis_ext = {axis[AXIS_W-1], axis};
    assign dzc      = $signed({2'b00, ctrl.dz_cont});
    assign dzs      = $signed({2'b00, ctrl.dz_step});
    assign cont_hit = (axis_ext >= dzc) || (axis_ext <= -dzc);
    assign step_pos = (axis_ext >= dzs);
    assign step_neg = (axis_ext <= -dzs);

    // continuous scaling, arithmetic shift gives floor
    logic signed [AXIS_W+LIMIT_W:0] scale_prod;
    logic signed [AXIS_W+LIMIT_W:0] scale_shr;

    assign scale_prod = axis * $signed({1'b0, ctrl.limit});
    assign scale_shr  = scale_prod >>> 15;

    // step with clamp
    logic signed [VEL_W+1:0] step_ext, lim_ext, lim_neg, step_sum;
    logic signed [VEL_W-1:0] step_res;

    assign step_ext = $signed({{(VEL_W+2-STEP_W){1'b0}}, ctrl.step});
    assign lim_ext  = $signed({{(VEL_W+2-LIMIT_W){1'b0}}, ctrl.limit});
    assign lim_neg  = -lim_ext;
    assign step_sum = {{2{target_reg[VEL_W-1]}}, target_reg}
                    + (step_pos ? step_ext : '0)
                    - (step_neg ? step_ext : '0);

    always_comb begin
        priority if (step_sum > lim_ext) begin
            step_res = lim_ext[VEL_W-1:0];
        end else if (step_sum < lim_neg) begin
            step_res = lim_neg[VEL_W-1:0];
        end else begin
            step_res = step_sum[VEL_W-1:0];
        end
    end

    always_comb begin
        target_next = target_reg;
        if (ctrl.sample_en) begin
            if (ctrl.mode == MODE_STEP) begin
                target_next = step_res;
            end else if (cont_hit) begin
                target_next = scale_shr[VEL_W-1:0];
            end
        end
    end

    // filter: f += ((65536 - beta) * (t - f)) >> 16
    logic signed [VEL_W:0]        diff;
    logic        [BETA_W:0]       gain;
    logic signed [VEL_W+BETA_W+1:0] filt_prod;
    logic signed [VEL_W+BETA_W+1:0] filt_shr;
    logic signed [VEL_W+1:0]      filt_sum;

    assign diff      = {target_reg[VEL_W-1], target_reg} - {filt_reg[VEL_W-1], filt_reg};
    assign gain      = {1'b1, {BETA_W{1'b0}}} - {1'b0, ctrl.beta};
    assign filt_prod = $signed({1'b0, gain}) * diff;
    assign filt_shr  = filt_prod >>> BETA_W;
    assign filt_sum  = {{2{filt_reg[VEL_W-1]}}, filt_reg} + filt_shr[VEL_W+1:0];
    assign vel_next  = filt_sum[VEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            filt_reg   <= '0;
        end else begin
            target_reg <= target_next;
            if (ctrl.tick_en) begin
                filt_reg <= vel_next;
            end
        end
    end

    `JVS_ASSERT_NEXT(a_step_clamped, ctrl.sample_en && ctrl.mode == MODE_STEP,
        target_reg <= $signed({1'b0, $past(ctrl.limit)})
        && target_reg >= -$signed({1'b0, $past(ctrl.limit)}),
        "step mode target outside limit")
    `JVS_ASSERT_NEXT(a_filt_hold, !ctrl.tick_en, $stable(filt_reg),
        "filtered value moved without a tick")
    `JVS_ASSERT_NEXT(a_target_hold, !ctrl.sample_en, $stable(target_reg),
        "target moved without a sample")

endmodule

// ===== sv/joystick_velocity_shaper_core.sv =====
// Joystick velocity shaper: dead zone / step shaping of three joystick axes
// followed by a first-order low-pass filter on each velocity.
//
// Input stream (s_*): one request per accepted beat. s_tuser is the kind:
// a joystick sample or a timer tick. A sample updates the three targets and
// gives no result. A tick after the first sample advances the filters and
// gives one result beat on m_* with the three filtered velocities; a tick
// before any sample gives nothing.
// Config port (cfg_*): register writes by index, always ready; intended to
// be written while the stream is idle. Writes past the last index are dropped.
// Timing: a request is captured in an input register and processed from there;
// a tick's result is written to the output register, which drives m_tvalid.
// Throughput is one request per cycle unless a tick waits for the output register; each
// axis needs one multiply for scaling and one for the filter per request.
// Reset (aresetn low, synchronous) restores register defaults and clears
// targets, filtered values and the sample-seen flag.
// When the receiver stalls, samples keep flowing; a tick waits in the input
// register until the output register is free, which stalls s_tready.
// depends on jvs_pkg, jvs_axis and joystick_velocity_shaper_core_macros.svh
`include "joystick_velocity_shaper_core_macros.svh"

module joystick_velocity_shaper_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,  // axis_x, axis_y, axis_yaw
    input  logic                               s_tuser,  // kind
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [47:0]                        m_tdata,  // vel_x, vel_y, vel_yaw
    // config writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [jvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jvs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jvs_pkg::*;

    // config registers
    logic               mode_reg;
    logic [DZ_W-1:0]    dz_cont_reg, dz_step_reg;
    logic [LIMIT_W-1:0] limit_lin_reg, limit_yaw_reg;
    logic [STEP_W-1:0]  step_lin_reg, step_yaw_reg;
    logic [BETA_W-1:0]  beta_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_RST;
            dz_cont_reg   <= DEAD_ZONE_CONT_RST;
            dz_step_reg   <= DEAD_ZONE_STEP_RST;
            limit_lin_reg <= LIMIT_LIN_RST;
            limit_yaw_reg <= LIMIT_YAW_RST;
            step_lin_reg  <= STEP_LIN_RST;
            step_yaw_reg  <= STEP_YAW_RST;
            beta_reg      <= BETA_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:           mode_reg      <= cfg_data[0];
                REG_DEAD_ZONE_CONT: dz_cont_reg   <= cfg_data[DZ_W-1:0];
                REG_DEAD_ZONE_STEP: dz_step_reg   <= cfg_data[DZ_W-1:0];
                REG_LIMIT_LIN:      limit_lin_reg <= cfg_data[LIMIT_W-1:0];
                REG_LIMIT_YAW:      limit_yaw_reg <= cfg_data[LIMIT_W-1:0];
                REG_STEP_LIN:       step_lin_reg  <= cfg_data[STEP_W-1:0];
                REG_STEP_YAW:       step_yaw_reg  <= cfg_data[STEP_W-1:0];
                REG_BETA:           beta_reg      <= cfg_data[BETA_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [47:0]       in_data_reg;
    logic              seen_reg;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;
    logic              has_result;
    logic              advance;

    assign has_result = in_kind_reg == KIND_TICK && seen_reg;
    assign advance    = in_valid_reg && (!has_result || !out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (advance && in_kind_reg == KIND_SAMPLE) begin
            seen_reg <= 1'b1;
        end
    end

    // axis units
    axis_ctrl_t ctrl_lin, ctrl_yaw;
    logic       sample_en, tick_en;
    logic signed [VEL_W-1:0] vel_x_next, vel_y_next, vel_yaw_next;

    assign sample_en = advance && in_kind_reg == KIND_SAMPLE;
    assign tick_en   = advance && has_result;

    assign ctrl_lin = '{sample_en: sample_en, tick_en: tick_en, mode: mode_reg,
                        dz_cont: dz_cont_reg, dz_step: dz_step_reg,
                        limit: limit_lin_reg, step: step_lin_reg, beta: beta_reg};
    assign ctrl_yaw = '{sample_en: sample_en, tick_en: tick_en, mode: mode_reg,
                        dz_cont: dz_cont_reg, dz_step: dz_step_reg,
                        limit: limit_yaw_reg, step: step_yaw_reg, beta: beta_reg};

    jvs_axis u_axis_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl_lin),
        .axis     ($signed(in_data_reg[15:0])),
        .vel_next (vel_x_next)
    );

    jvs_axis u_axis_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl_lin),
        .axis     ($signed(in_data_reg[31:16])),
        .vel_next (vel_y_next)
    );

    jvs_axis u_axis_yaw (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl_yaw),
        .axis     ($signed(in_data_reg[47:32])),
        .vel_next (vel_yaw_next)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (tick_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            out_data_reg <= {vel_yaw_next, vel_y_next, vel_x_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `JVS_ASSERT_NOW(a_result_from_tick, $rose(out_valid_reg),
        $past(in_valid_reg && in_kind_reg == KIND_TICK && seen_reg),
        "result without a tick after a sample")
    `JVS_ASSERT_NEXT(a_seen_sticky, seen_reg, seen_reg,
        "sample-seen flag cleared outside reset")
    `JVS_ASSERT_NEXT(a_tick_kept, in_valid_reg && has_result && out_valid_reg && !m_tready,
        in_valid_reg && $stable(in_data_reg),
        "stalled tick lost from input register")

endmodule
